/* design/b64d_pkg.sv */
// b64d_pkg: shared types, constants and the character map of the base64 stream decoder.
// Depends on nothing; base64_stream_decoder, b64d_assemble and b64d_emit import it.
package b64d_pkg;

  localparam int unsigned CODE_W    = 6;
  localparam int unsigned ENTRY_W   = CODE_W + 1;
  localparam int unsigned VALID_BIT = CODE_W;

  // held code: bit 6 flags a valid character, bits 5..0 the code
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam entry_t INVALID_ENTRY = entry_t'(7'h3f);
  localparam entry_t VALID_FLAG    = entry_t'(7'h40);

  localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_Z  = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC_Z  = 8'h7a;  // 'z'
  localparam logic [7:0] CH_DIG_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CH_UNDER = 8'h5f;  // '_'
  localparam logic [7:0] CH_LT    = 8'h3c;  // '<'

  localparam logic [7:0] LC_OFS  = 8'd26;
  localparam logic [7:0] DIG_OFS = 8'd52;

  // one closed group on its way to the output side
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [2:0]      mask;   // bit k set: byte k is due
    logic            eot;    // group closed by the end of the message
  } grp_t;

  function automatic entry_t b64d_map(input logic [7:0] c);
    logic [7:0] v;
    entry_t     e;
    v = 8'd0;
    e = INVALID_ENTRY;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      v = c - CH_UC_A;
      e = VALID_FLAG | entry_t'(v[CODE_W-1:0]);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      v = c - CH_LC_A + LC_OFS;
      e = VALID_FLAG | entry_t'(v[CODE_W-1:0]);
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      v = c - CH_DIG_0 + DIG_OFS;
      e = VALID_FLAG | entry_t'(v[CODE_W-1:0]);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      e = VALID_FLAG | entry_t'(7'd62);
    end else if (c == CH_SLASH || c == CH_UNDER) begin
      e = VALID_FLAG | entry_t'(7'd63);
    end else if (c == CH_LT) begin
      e = VALID_FLAG;
    end
    return e;
  endfunction

endpackage

/* design/b64d_in_if.sv */
// b64d_in_if: valid/ready channel carrying one encoded character and its end flag.
// No dependencies.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

/* design/b64d_out_if.sv */
// b64d_out_if: valid/ready channel carrying one decoded byte and its flags.
// No dependencies.
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_done;
  logic       run_last;

  modport source (output valid, output data_byte, output byte_valid,
                  output message_done, output run_last, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input message_done, input run_last, output ready);
endinterface

/* design/base64_stream_decoder.sv */
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_assemble and b64d_emit.
//
// Usage: in_ch takes one encoded character per transfer with end_of_text set on
// the last one of a message. out_ch gives decoded bytes, one per transfer;
// run_last marks the last result caused by an input character and message_done
// the last result of a message. A message end with no byte due still gives one
// result with byte_valid low. Characters outside the alphabet count as invalid.
// With the output side idle, a character that closes a group passes the group register
// in b64d_assemble and then the current-group register in b64d_emit before its first
// result shows on out_ch. Throughput: one character per cycle while in_ch is not held
// off; up to three bytes per closed group leave at one per cycle while out_ch is ready,
// which keeps pace with four characters in.
// One group waits in a register while the previous one drains, so a stalled
// receiver holds off in_ch only once both are occupied.
// Reset (rst_n low, synchronous) empties both registers and restarts the group.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);

  logic grp_valid;
  logic grp_take;
  grp_t grp;

  b64d_assemble u_assemble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .grp_take  (grp_take),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  b64d_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take),
    .out_ch    (out_ch)
  );

endmodule

/* design/b64d_assemble.sv */
// b64d_assemble: maps characters to codes, collects groups of four and registers
// each closed group with its byte mask. Depends on b64d_pkg and b64d_in_if.
module b64d_assemble import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  b64d_in_if.sink   in_ch,
  input  logic      grp_take,
  output logic      grp_valid,
  output grp_t      grp
);

  logic [1:0] pos_r, pos_nxt;
  entry_t     held_r [3];
  logic       grp_v_r, grp_v_nxt;
  grp_t       grp_r, grp_nxt;

  entry_t     code;
  entry_t     g [4];
  logic       accept;
  logic       closes;
  logic       emits;

  assign in_ch.ready = !grp_v_r || grp_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign code        = b64d_map(in_ch.char_code);
  assign closes      = (pos_r == 2'd3) || in_ch.end_of_text;

  // codes past the current position are missing and count as invalid
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pos_r)       g[i] = held_r[i];
      else if (2'(i) == pos_r) g[i] = code;
      else                     g[i] = INVALID_ENTRY;
    end
    g[3] = (pos_r == 2'd3) ? code : INVALID_ENTRY;
  end

  always_comb begin
    grp_nxt.bytes[0] = {g[0][5:0], g[1][5:4]};
    grp_nxt.bytes[1] = {g[1][3:0], g[2][5:2]};
    grp_nxt.bytes[2] = {g[2][1:0], g[3][5:0]};
    grp_nxt.mask     = {g[3][VALID_BIT], g[2][VALID_BIT], g[1][VALID_BIT]};
    grp_nxt.eot      = in_ch.end_of_text;
  end

  // a closed group with nothing due and no end flag produces no record
  assign emits = accept && closes && ((grp_nxt.mask != 3'b000) || in_ch.end_of_text);

  always_comb begin
    pos_nxt = pos_r;
    if (accept) pos_nxt = closes ? 2'd0 : pos_r + 2'd1;
    grp_v_nxt = grp_v_r;
    if (grp_take)  grp_v_nxt = 1'b0;
    if (emits)     grp_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      grp_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      grp_v_r <= grp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closes) held_r[pos_r] <= code;
    if (emits)             grp_r <= grp_nxt;
  end

  assign grp_valid = grp_v_r;
  assign grp       = grp_r;

  a_eot_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_text) |=> (pos_r == 2'd0))
    else $error("group position not cleared after end of message");

  a_grp_held: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_v_r && !grp_take) |=> (grp_v_r && $stable(grp_r)))
    else $error("pending group lost or altered");

endmodule

/* design/b64d_emit.sv */
// b64d_emit: holds the group being sent and transfers its bytes one per cycle while out_ch
// is ready, plus the end marker when no byte is due. Depends on b64d_pkg and b64d_out_if.
module b64d_emit import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_valid,
  input  grp_t       grp,
  output logic       grp_take,
  b64d_out_if.source out_ch
);

  logic       cur_v_r, cur_v_nxt;
  grp_t       cur_r, cur_nxt;
  logic [2:0] rest;
  logic       last;
  logic       xfer;
  logic [7:0] sel_byte;

  always_comb begin
    sel_byte = 8'd0;
    if (cur_r.mask[0])      sel_byte = cur_r.bytes[0];
    else if (cur_r.mask[1]) sel_byte = cur_r.bytes[1];
    else if (cur_r.mask[2]) sel_byte = cur_r.bytes[2];
  end

  // drop the lowest pending byte
  assign rest     = cur_r.mask & (cur_r.mask - 3'd1);
  assign last     = (rest == 3'b000);
  assign xfer     = out_ch.valid && out_ch.ready;
  assign grp_take = grp_valid && (!cur_v_r || (xfer && last));

  always_comb begin
    cur_v_nxt = cur_v_r;
    cur_nxt   = cur_r;
    if (xfer) begin
      cur_nxt.mask = rest;
      if (last) cur_v_nxt = 1'b0;
    end
    if (grp_take) begin
      cur_v_nxt = 1'b1;
      cur_nxt   = grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cur_v_r <= 1'b0;
    else        cur_v_r <= cur_v_nxt;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_ch.valid        = cur_v_r;
  assign out_ch.data_byte    = sel_byte;
  assign out_ch.byte_valid   = (cur_r.mask != 3'b000);
  assign out_ch.run_last     = last;
  assign out_ch.message_done = cur_r.eot && last;

  a_no_empty_record: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> ((cur_r.mask != 3'b000) || cur_r.eot))
    else $error("record with nothing to send");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && out_ch.message_done) |-> out_ch.run_last)
    else $error("message end not on last result of item");

endmodule

/* dv/base64_stream_decoder_test.sv */
`timescale 1ns / 100ps
// base64_stream_decoder_test: self-checking testbench of the base64 stream decoder.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and base64_stream_decoder from design/.
module base64_stream_decoder_test;
  import b64d_pkg::*;

  localparam int HOLD_CYCLES    = 120;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_MSG_PRINTS = 40;

  localparam logic [7:0] CH_PAD = 8'h3d;  // '='

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    logic       run_last;
  } dec_result_t;

  logic clk;
  logic rst_n;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // decoder state as predicted
  logic [1:0] grp_pos;
  entry_t     held [3];

  dec_result_t expected_bytes [$];

  int  mismatches;
  int  results_seen;
  int  chars_sent;
  int  messages_sent;
  int  idle_count;
  int  hold_left;
  bit  hold_request;
  bit  send_gaps_on;
  bit  recv_gaps_on;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic entry_t char_entry(input logic [7:0] c);
    entry_t e;
    e = INVALID_ENTRY;
    if (c == CH_PLUS || c == CH_MINUS) begin
      e = VALID_FLAG | entry_t'(7'd62);
    end else if (c == CH_SLASH || c == CH_UNDER) begin
      e = VALID_FLAG | entry_t'(7'd63);
    end else if (c == CH_LT) begin
      e = VALID_FLAG;
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      e = VALID_FLAG | entry_t'(c - CH_DIG_0 + DIG_OFS);
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      e = VALID_FLAG | entry_t'(c - CH_UC_A);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      e = VALID_FLAG | entry_t'(c - CH_LC_A + LC_OFS);
    end
    return e;
  endfunction

  function automatic void predict_char(input logic [7:0] c, input logic eot);
    entry_t      g [4];
    logic [7:0]  b [3];
    dec_result_t r;
    dec_result_t run [$];
    g[0] = INVALID_ENTRY;
    g[1] = INVALID_ENTRY;
    g[2] = INVALID_ENTRY;
    g[3] = INVALID_ENTRY;
    if (grp_pos != 2'd3 && !eot) begin
      held[grp_pos] = char_entry(c);
      grp_pos = grp_pos + 2'd1;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      if (i < grp_pos) begin
        g[i] = held[i];
      end else if (i == grp_pos) begin
        g[i] = char_entry(c);
      end
    end
    grp_pos = 2'd0;
    b[0] = {g[0][5:0], g[1][5:4]};
    b[1] = {g[1][3:0], g[2][5:2]};
    b[2] = {g[2][1:0], g[3][5:0]};
    for (int k = 0; k < 3; k++) begin
      if (g[k+1][VALID_BIT]) begin
        r = '{data_byte: b[k], byte_valid: 1'b1, message_done: 1'b0, run_last: 1'b0};
        run = {run, r};
      end
    end
    // end of message with nothing due still yields one empty result
    if (run.size() == 0 && eot) begin
      r = '{data_byte: 8'h00, byte_valid: 1'b0, message_done: 1'b0, run_last: 1'b0};
      run = {run, r};
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_last     = 1'b1;
      run[run.size()-1].message_done = eot;
    end
    foreach (run[i]) expected_bytes = {expected_bytes, run[i]};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_MSG_PRINTS) begin
      $display("[%0t] mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
               $time, results_seen, what, got, want);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    dec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result, data_byte", out_ch.data_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.data_byte !== want.data_byte)
          report_mismatch("data_byte", out_ch.data_byte, want.data_byte);
        if (out_ch.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", out_ch.byte_valid, want.byte_valid);
        if (out_ch.message_done !== want.message_done)
          report_mismatch("message_done", out_ch.message_done, want.message_done);
        if (out_ch.run_last !== want.run_last)
          report_mismatch("run_last", out_ch.run_last, want.run_last);
      end
      results_seen++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= recv_gaps_on ? ($urandom_range(99) >= 20) : 1'b1;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eot);
    @(negedge clk);
    if (send_gaps_on) begin
      while ($urandom_range(99) < 20) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_char(c, eot);
    chars_sent++;
    if (eot) messages_sent++;
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] random_alphabet_char();
    int unsigned i;
    i = $urandom_range(0, 66);
    if (i < 26) return CH_UC_A + 8'(i);
    if (i < 52) return CH_LC_A + 8'(i - 26);
    if (i < 62) return CH_DIG_0 + 8'(i - 52);
    case (i)
      62:      return CH_PLUS;
      63:      return CH_SLASH;
      64:      return CH_MINUS;
      65:      return CH_UNDER;
      default: return CH_LT;
    endcase
  endfunction

  // mostly alphabet, some padding, some arbitrary bytes
  function automatic logic [7:0] random_char();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 80) return random_alphabet_char();
    if (k < 88) return CH_PAD;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_messages(input int n_chars, input bit alphabet_only);
    int unsigned len;
    int          sent;
    bit          eot_last;
    sent = 0;
    while (sent < n_chars) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 12);
      eot_last = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
        send_char(alphabet_only ? random_alphabet_char() : random_char(),
                  eot_last && (i == len - 1));
      end
      sent += len;
    end
  endtask

  task automatic test_alphabet();
    send_text("AZaz", 1'b0);
    send_text("09+-", 1'b0);
    send_text("/_<A", 1'b1);
  endtask

  // characters outside the table, incl. one just above 'z'
  task automatic test_invalid_chars();
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h7b, 1'b0);
  endtask

  // message end at group positions 0, 1 and 2; first one has no byte due
  task automatic test_message_end();
    send_text("=", 1'b1);
    send_text("QQ", 1'b1);
    send_text("QUI", 1'b1);
  endtask

  task automatic test_random_messages();
    send_random_messages(50, 1'b0);
  endtask

  task automatic test_burst_no_gaps();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    send_random_messages(24, 1'b1);
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  // receiver stalls long enough for the block to fill and push back on in_ch
  task automatic test_receiver_hold_off();
    send_gaps_on = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    hold_request = 1'b1;
    send_random_messages(28, 1'b1);
    send_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = 8'h00;
    in_ch.end_of_text  = 1'b0;
    out_ch.ready       = 1'b0;
    grp_pos            = 2'd0;
    mismatches         = 0;
    results_seen       = 0;
    chars_sent         = 0;
    messages_sent      = 0;
    idle_count         = 0;
    hold_left          = 0;
    hold_request       = 1'b0;
    send_gaps_on       = 1'b1;
    recv_gaps_on       = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_alphabet();
    test_invalid_chars();
    test_message_end();
    test_random_messages();
    test_burst_no_gaps();
    test_receiver_hold_off();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d terminated messages, %0d results checked",
             chars_sent, messages_sent, results_seen);
    $display("incl. full alphabet, invalid bytes, early message ends and output back-pressure");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
